// ===== hw/rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int HUE_BITS         = 13;
    localparam int HUE_SECTOR       = 960;
    localparam int HUE_FULL         = 5760;
    localparam int HUE_QUO_BITS     = 10;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } hsv_sector_t;

    typedef struct packed {
        hsv_sector_t sector;
        logic        neg;
        logic        grey;
    } hsv_flags_t;

endpackage

// ===== hw/rtl/rgbhsv_rgb_if.sv =====
interface rgbhsv_rgb_if
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/rgbhsv_hsv_if.sv =====
interface rgbhsv_hsv_if
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV pixel converter. Takes one word of red, green and blue and returns
// hue (1/16 degree, 0..5759), saturation (floor(max_code*delta/max)) and
// brightness (largest channel); grey pixels give hue and saturation of zero.
// Throughput is one pixel per clock while the output is not stalled. The pipeline has
// two front stages (extremes, then delta and dividends), one stage per quotient
// bit in the restoring divider that produces saturation and hue in parallel, and
// the output register, with QUO_BITS = max(CHANNEL_BITS, 10) quotient bits.
// Backpressure stalls each stage only when its successor is full.
module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rgbhsv_rgb_if.sink    pixel_in,
    rgbhsv_hsv_if.source  pixel_out
);
    localparam int QUO_BITS = (CHANNEL_BITS > HUE_QUO_BITS) ? CHANNEL_BITS : HUE_QUO_BITS;
    localparam int DW       = QUO_BITS + CHANNEL_BITS;
    localparam int SUM_BITS = HUE_BITS + 1;

    logic                    fr_valid;
    logic                    fr_ready;
    logic [DW-1:0]           fr_sat;
    logic [DW-1:0]           fr_hue;
    logic [CHANNEL_BITS-1:0] fr_div;
    logic [CHANNEL_BITS-1:0] fr_bri;
    hsv_flags_t              fr_flags;

    logic                    dv_valid;
    logic                    dv_ready;
    logic [QUO_BITS-1:0]     dv_sat;
    logic [QUO_BITS-1:0]     dv_hue;
    logic [CHANNEL_BITS-1:0] dv_bri;
    hsv_flags_t              dv_flags;

    logic                    out_valid_reg;
    logic [HUE_BITS-1:0]     hue_reg;
    logic [CHANNEL_BITS-1:0] sat_reg;
    logic [CHANNEL_BITS-1:0] bri_reg;
    logic [HUE_BITS-1:0]     hue_next;
    logic [CHANNEL_BITS-1:0] sat_next;
    logic [SUM_BITS-1:0]     offset;
    logic [SUM_BITS-1:0]     quo;
    logic [SUM_BITS-1:0]     hue_sum;
    logic                    out_load;

    rgbhsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .QUO_BITS     (QUO_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixel_in.valid),
        .in_ready     (pixel_in.ready),
        .red          (pixel_in.red),
        .green        (pixel_in.green),
        .blue         (pixel_in.blue),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .sat_dividend (fr_sat),
        .hue_dividend (fr_hue),
        .divisor      (fr_div),
        .brightness   (fr_bri),
        .flags        (fr_flags)
    );

    rgbhsv_div #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .QUO_BITS     (QUO_BITS)
    ) u_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (fr_valid),
        .in_ready       (fr_ready),
        .sat_dividend   (fr_sat),
        .hue_dividend   (fr_hue),
        .divisor        (fr_div),
        .in_brightness  (fr_bri),
        .in_flags       (fr_flags),
        .out_valid      (dv_valid),
        .out_ready      (dv_ready),
        .sat_quo        (dv_sat),
        .hue_quo        (dv_hue),
        .out_brightness (dv_bri),
        .out_flags      (dv_flags)
    );

    assign out_load = !out_valid_reg || pixel_out.ready;
    assign dv_ready = out_load;

    always_comb
    begin
        case (dv_flags.sector)
            SECT_RED:   offset = '0;
            SECT_GREEN: offset = SUM_BITS'(2 * HUE_SECTOR);
            SECT_BLUE:  offset = SUM_BITS'(4 * HUE_SECTOR);
            default:    offset = '0;
        endcase
        quo = SUM_BITS'(dv_hue[HUE_QUO_BITS-1:0]);
        if (!dv_flags.neg)
            hue_sum = offset + quo;
        else if (offset >= quo)
            hue_sum = offset - quo;
        else
            hue_sum = offset + SUM_BITS'(HUE_FULL) - quo;  // wrap below zero
        hue_next = dv_flags.grey ? '0 : hue_sum[HUE_BITS-1:0];
        sat_next = dv_flags.grey ? '0 : dv_sat[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && dv_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= dv_bri;
        end
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.hue        = hue_reg;
    assign pixel_out.saturation = sat_reg;
    assign pixel_out.brightness = bri_reg;

`ifndef NO_ASSERTIONS
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> hue_reg < HUE_BITS'(HUE_FULL))
        else $error("hue outside full circle");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg == '0 |-> hue_reg == '0)
        else $error("zero saturation with non-zero hue");

    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bri_reg == '0 |-> sat_reg == '0)
        else $error("black pixel with non-zero saturation");
`endif
endmodule

// ===== hw/rtl/rgbhsv_front.sv =====
module rgbhsv_front
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int QUO_BITS     = HUE_QUO_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [CHANNEL_BITS-1:0]          red,
    input  logic [CHANNEL_BITS-1:0]          green,
    input  logic [CHANNEL_BITS-1:0]          blue,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [QUO_BITS+CHANNEL_BITS-1:0] sat_dividend,
    output logic [QUO_BITS+CHANNEL_BITS-1:0] hue_dividend,
    output logic [CHANNEL_BITS-1:0]          divisor,
    output logic [CHANNEL_BITS-1:0]          brightness,
    output hsv_flags_t                       flags
);
    localparam int DW = QUO_BITS + CHANNEL_BITS;

    // stage 1: extremes and sector
    logic                    s1_valid_reg;
    logic [CHANNEL_BITS-1:0] s1_red_reg;
    logic [CHANNEL_BITS-1:0] s1_green_reg;
    logic [CHANNEL_BITS-1:0] s1_blue_reg;
    logic [CHANNEL_BITS-1:0] s1_max_reg;
    logic [CHANNEL_BITS-1:0] s1_min_reg;
    hsv_sector_t             s1_sector_reg;
    logic [CHANNEL_BITS-1:0] s1_max_next;
    logic [CHANNEL_BITS-1:0] s1_min_next;
    hsv_sector_t             s1_sector_next;
    logic                    s1_load;

    // stage 2: delta, difference and dividends
    logic                    s2_valid_reg;
    logic [DW-1:0]           s2_sat_reg;
    logic [DW-1:0]           s2_hue_reg;
    logic [CHANNEL_BITS-1:0] s2_delta_reg;
    logic [CHANNEL_BITS-1:0] s2_max_reg;
    hsv_flags_t              s2_flags_reg;
    logic [DW-1:0]           s2_sat_next;
    logic [DW-1:0]           s2_hue_next;
    logic [CHANNEL_BITS-1:0] s2_delta_next;
    hsv_flags_t              s2_flags_next;
    logic [CHANNEL_BITS:0]   diff;
    logic [CHANNEL_BITS:0]   diff_abs;
    logic                    s2_load;

    assign s2_load  = !s2_valid_reg || out_ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_comb
    begin
        s1_max_next = red;
        s1_min_next = red;
        if (green > s1_max_next)
            s1_max_next = green;
        if (blue > s1_max_next)
            s1_max_next = blue;
        if (green < s1_min_next)
            s1_min_next = green;
        if (blue < s1_min_next)
            s1_min_next = blue;
        if (s1_max_next == red)
            s1_sector_next = SECT_RED;
        else if (s1_max_next == green)
            s1_sector_next = SECT_GREEN;
        else
            s1_sector_next = SECT_BLUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_red_reg    <= red;
            s1_green_reg  <= green;
            s1_blue_reg   <= blue;
            s1_max_reg    <= s1_max_next;
            s1_min_reg    <= s1_min_next;
            s1_sector_reg <= s1_sector_next;
        end
    end

    always_comb
    begin
        case (s1_sector_reg)
            SECT_RED:   diff = {1'b0, s1_green_reg} - {1'b0, s1_blue_reg};
            SECT_GREEN: diff = {1'b0, s1_blue_reg} - {1'b0, s1_red_reg};
            SECT_BLUE:  diff = {1'b0, s1_red_reg} - {1'b0, s1_green_reg};
            default:    diff = '0;
        endcase
        diff_abs             = diff[CHANNEL_BITS] ? (~diff + 1'b1) : diff;
        s2_delta_next        = s1_max_reg - s1_min_reg;
        // max * delta with max = 2^n - 1
        s2_sat_next          = (DW'(s2_delta_next) << CHANNEL_BITS) - DW'(s2_delta_next);
        s2_hue_next          = DW'(diff_abs[CHANNEL_BITS-1:0]) * DW'(HUE_SECTOR);
        s2_flags_next.sector = s1_sector_reg;
        s2_flags_next.neg    = diff[CHANNEL_BITS];
        s2_flags_next.grey   = (s2_delta_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_sat_reg   <= s2_sat_next;
            s2_hue_reg   <= s2_hue_next;
            s2_delta_reg <= s2_delta_next;
            s2_max_reg   <= s1_max_reg;
            s2_flags_reg <= s2_flags_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign sat_dividend = s2_sat_reg;
    assign hue_dividend = s2_hue_reg;
    assign divisor      = s2_delta_reg;
    assign brightness   = s2_max_reg;
    assign flags        = s2_flags_reg;
endmodule

// ===== hw/rtl/rgbhsv_div.sv =====
module rgbhsv_div
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int QUO_BITS     = HUE_QUO_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [QUO_BITS+CHANNEL_BITS-1:0] sat_dividend,
    input  logic [QUO_BITS+CHANNEL_BITS-1:0] hue_dividend,
    input  logic [CHANNEL_BITS-1:0]          divisor,
    input  logic [CHANNEL_BITS-1:0]          in_brightness,
    input  hsv_flags_t                       in_flags,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [QUO_BITS-1:0]              sat_quo,
    output logic [QUO_BITS-1:0]              hue_quo,
    output logic [CHANNEL_BITS-1:0]          out_brightness,
    output hsv_flags_t                       out_flags
);
    localparam int DW = QUO_BITS + CHANNEL_BITS;

    // one quotient bit per stage; saturation divides by brightness, hue by delta
    logic                    valid_reg [QUO_BITS];
    logic [CHANNEL_BITS-1:0] rem_s_reg [QUO_BITS];
    logic [CHANNEL_BITS-1:0] rem_h_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     low_s_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     low_h_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     quo_s_reg [QUO_BITS];
    logic [QUO_BITS-1:0]     quo_h_reg [QUO_BITS];
    logic [CHANNEL_BITS-1:0] div_reg   [QUO_BITS];
    logic [CHANNEL_BITS-1:0] bri_reg   [QUO_BITS];
    hsv_flags_t              flags_reg [QUO_BITS];
    logic [QUO_BITS:0]       load;

    assign load[QUO_BITS] = out_ready;
    assign in_ready       = load[0];

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_stage
        logic                    v_in;
        logic [CHANNEL_BITS-1:0] rem_s_in;
        logic [CHANNEL_BITS-1:0] rem_h_in;
        logic [QUO_BITS-1:0]     low_s_in;
        logic [QUO_BITS-1:0]     low_h_in;
        logic [QUO_BITS-1:0]     quo_s_in;
        logic [QUO_BITS-1:0]     quo_h_in;
        logic [CHANNEL_BITS-1:0] div_in;
        logic [CHANNEL_BITS-1:0] bri_in;
        hsv_flags_t              flags_in;
        logic [CHANNEL_BITS:0]   trial_s;
        logic [CHANNEL_BITS:0]   trial_h;
        logic [CHANNEL_BITS:0]   sub_s;
        logic [CHANNEL_BITS:0]   sub_h;
        logic                    ge_s;
        logic                    ge_h;
        logic [CHANNEL_BITS-1:0] rem_s_next;
        logic [CHANNEL_BITS-1:0] rem_h_next;

        if (k == 0)
        begin : g_first
            assign v_in     = in_valid;
            assign rem_s_in = sat_dividend[DW-1:QUO_BITS];
            assign rem_h_in = hue_dividend[DW-1:QUO_BITS];
            assign low_s_in = sat_dividend[QUO_BITS-1:0];
            assign low_h_in = hue_dividend[QUO_BITS-1:0];
            assign quo_s_in = '0;
            assign quo_h_in = '0;
            assign div_in   = divisor;
            assign bri_in   = in_brightness;
            assign flags_in = in_flags;
        end
        else
        begin : g_next
            assign v_in     = valid_reg[k-1];
            assign rem_s_in = rem_s_reg[k-1];
            assign rem_h_in = rem_h_reg[k-1];
            assign low_s_in = low_s_reg[k-1];
            assign low_h_in = low_h_reg[k-1];
            assign quo_s_in = quo_s_reg[k-1];
            assign quo_h_in = quo_h_reg[k-1];
            assign div_in   = div_reg[k-1];
            assign bri_in   = bri_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        assign trial_s    = {rem_s_in, low_s_in[QUO_BITS-1]};
        assign trial_h    = {rem_h_in, low_h_in[QUO_BITS-1]};
        assign sub_s      = trial_s - {1'b0, bri_in};
        assign sub_h      = trial_h - {1'b0, div_in};
        assign ge_s       = (trial_s >= {1'b0, bri_in});
        assign ge_h       = (trial_h >= {1'b0, div_in});
        assign rem_s_next = ge_s ? sub_s[CHANNEL_BITS-1:0] : trial_s[CHANNEL_BITS-1:0];
        assign rem_h_next = ge_h ? sub_h[CHANNEL_BITS-1:0] : trial_h[CHANNEL_BITS-1:0];
        assign load[k]    = !valid_reg[k] || load[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (load[k])
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (load[k] && v_in)
            begin
                rem_s_reg[k] <= rem_s_next;
                rem_h_reg[k] <= rem_h_next;
                low_s_reg[k] <= low_s_in << 1;
                low_h_reg[k] <= low_h_in << 1;
                quo_s_reg[k] <= {quo_s_in[QUO_BITS-2:0], ge_s};
                quo_h_reg[k] <= {quo_h_in[QUO_BITS-2:0], ge_h};
                div_reg[k]   <= div_in;
                bri_reg[k]   <= bri_in;
                flags_reg[k] <= flags_in;
            end
        end
    end

    assign out_valid      = valid_reg[QUO_BITS-1];
    assign sat_quo        = quo_s_reg[QUO_BITS-1];
    assign hue_quo        = quo_h_reg[QUO_BITS-1];
    assign out_brightness = bri_reg[QUO_BITS-1];
    assign out_flags      = flags_reg[QUO_BITS-1];

`ifndef NO_ASSERTIONS
    a_hue_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_flags.grey |-> hue_quo <= QUO_BITS'(HUE_SECTOR))
        else $error("hue quotient above one sector");

    a_sat_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_flags.grey |-> (sat_quo >> CHANNEL_BITS) == '0)
        else $error("saturation quotient overflows channel width");
`endif
endmodule

// ===== dv/tb_rgb_to_hsv_converter.sv =====
module tb_rgb_to_hsv_converter;
    import rgbhsv_pkg::*;

    localparam int CB           = CHANNEL_BITS_DEF;
    localparam int CHAN_MAX     = (1 << CB) - 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 90;
    localparam int SETTLE       = 20;
    localparam int PHASE_WORDS  = 592;
    localparam int N_DIRECTED   = 24;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [CB-1:0]       sat;
        logic [CB-1:0]       bri;
    } hsv_word_t;

    typedef struct packed {
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        logic          typed;
        hsv_word_t     want;
    } pixel_row_t;

    // typed rows carry their answer, the rest go through the predictor
    localparam pixel_row_t PIXEL_TABLE [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    8'd0,   8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    8'd0,   8'd255}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{13'd0,    8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{13'd1920, 8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{13'd3840, 8'd255, 8'd255}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{13'd960,  8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{13'd2880, 8'd255, 8'd255}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{13'd4800, 8'd255, 8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{13'd0,    8'd0,   8'd128}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{13'd0,    8'd0,   8'd1}},
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{8'd0,   8'd1,   8'd0,   1'b0, '0},
        '{8'd0,   8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd1,   8'd0,   1'b0, '0},
        '{8'd254, 8'd255, 8'd0,   1'b0, '0},
        '{8'd128, 8'd127, 8'd127, 1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd255, 8'd255, 8'd254, 1'b0, '0},
        '{8'd0,   8'd255, 8'd254, 1'b0, '0},
        '{8'd254, 8'd0,   8'd255, 1'b0, '0},
        '{8'd170, 8'd85,  8'd0,   1'b0, '0},
        '{8'd85,  8'd170, 8'd255, 1'b0, '0},
        '{8'd200, 8'd10,  8'd100, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rgbhsv_rgb_if #(.CHANNEL_BITS(CB)) pix_in ();
    rgbhsv_hsv_if #(.CHANNEL_BITS(CB)) hsv_out ();

    rgb_to_hsv_converter #(.CHANNEL_BITS(CB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_in),
        .pixel_out (hsv_out)
    );

    always #2 clk = ~clk;

    hsv_word_t hsv_due [$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        long_hold = 1'b0;
    int        quiet_cycles = 0;

    function automatic hsv_word_t hsv_of_pixel(input logic [CB-1:0] r, g, b);
        int          mx, mn, delta, diff, h;
        hsv_sector_t sect;
        hsv_word_t   res;
        mx = int'(r);
        mn = int'(r);
        if (int'(g) > mx) mx = int'(g);
        if (int'(b) > mx) mx = int'(b);
        if (int'(g) < mn) mn = int'(g);
        if (int'(b) < mn) mn = int'(b);
        delta = mx - mn;
        res = '0;
        res.bri = mx[CB-1:0];
        if (delta != 0)
        begin
            h = (CHAN_MAX * delta) / mx;
            res.sat = h[CB-1:0];
            if (mx == int'(r))
            begin
                sect = SECT_RED;
                diff = int'(g) - int'(b);
            end
            else if (mx == int'(g))
            begin
                sect = SECT_GREEN;
                diff = int'(b) - int'(r);
            end
            else
            begin
                sect = SECT_BLUE;
                diff = int'(r) - int'(g);
            end
            // signed int division truncates toward zero
            h = 2 * HUE_SECTOR * int'(sect) + (HUE_SECTOR * diff) / delta;
            if (h < 0) h += HUE_FULL;
            res.hue = h[HUE_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] %s mismatch: got %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    task automatic send_pixel(input logic [CB-1:0] r, g, b, input bit typed,
                              input hsv_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red   <= r;
        pix_in.green <= g;
        pix_in.blue  <= b;
        do @(posedge clk); while (!pix_in.ready);
        hsv_due.push_back(typed ? want : hsv_of_pixel(r, g, b));
    endtask

    // biased towards greys, ties and extremes; the rest uniform
    task automatic send_random_pixel();
        logic [CB-1:0] r, g, b;
        r = CB'($urandom_range(CHAN_MAX));
        g = CB'($urandom_range(CHAN_MAX));
        b = CB'($urandom_range(CHAN_MAX));
        case ($urandom_range(9))
            0: begin g = r; b = r; end
            1: begin
                   case ($urandom_range(2))
                       0: g = r;
                       1: b = g;
                       default: b = r;
                   endcase
               end
            2: begin
                   r = CB'($urandom_range(3));
                   g = CB'($urandom_range(3));
                   b = CB'($urandom_range(3));
               end
            3: begin
                   r = CB'($urandom_range(1) ? CHAN_MAX : 0);
                   g = CB'($urandom_range(1) ? CHAN_MAX : $urandom_range(CHAN_MAX));
                   b = CB'($urandom_range(1) ? 0 : $urandom_range(CHAN_MAX));
               end
            default: ;
        endcase
        send_pixel(r, g, b, 1'b0, '0);
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (hsv_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        pix_in.valid = 1'b0;
        pix_in.red   = '0;
        pix_in.green = '0;
        pix_in.blue  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 52;
        foreach (PIXEL_TABLE[i])
            send_pixel(PIXEL_TABLE[i].r, PIXEL_TABLE[i].g, PIXEL_TABLE[i].b,
                       PIXEL_TABLE[i].typed, PIXEL_TABLE[i].want);
        repeat (PHASE_WORDS) send_random_pixel();
        wait_drained();

        send_idle_pct = 52;
        recv_idle_pct = 12;
        repeat (PHASE_WORDS) send_random_pixel();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (100) send_random_pixel();
        // sink stalls long enough for the pipe to fill and push back
        long_hold = 1'b1;
        repeat (PHASE_WORDS) send_random_pixel();
        wait_drained();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        hsv_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                hsv_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            hsv_out.ready <= ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        hsv_word_t want;
        if (rst_n && hsv_out.valid && hsv_out.ready)
        begin
            if (hsv_due.size() == 0)
            begin
                $display("[%0t] unexpected word: hue %0d sat %0d val %0d", $time,
                         hsv_out.hue, hsv_out.saturation, hsv_out.brightness);
                errors++;
            end
            else
            begin
                want = hsv_due.pop_front();
                if (hsv_out.hue !== want.hue)
                    report_mismatch("hue", int'(hsv_out.hue), int'(want.hue));
                if (hsv_out.saturation !== want.sat)
                    report_mismatch("saturation", int'(hsv_out.saturation),
                                    int'(want.sat));
                if (hsv_out.brightness !== want.bri)
                    report_mismatch("brightness", int'(hsv_out.brightness),
                                    int'(want.bri));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (hsv_out.valid && hsv_out.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
